// ===== rtl/mwf_pkg.sv =====
// Shared types and constants of the prefix mass window filter.
`timescale 1ns / 1ps

package mwf_pkg;

    localparam int MASS_W      = 31;
    localparam int SHIFT_W     = 21;
    localparam int TOL_W       = 16;
    localparam int SCNT_W      = 3;
    localparam int NODE_W      = 6;
    localparam int SHIFT_REGS  = 4;
    localparam int MAX_SHIFTS  = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;
    localparam int CALC_W      = 34;

    localparam logic [TOL_W-1:0] DEFAULT_TOL = 16'd27;

    localparam logic [CFG_IDX_W-1:0] REG_PRECURSOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_CNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_A   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_B   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_C   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_D   = 3'd6;

    typedef struct packed {
        logic [MASS_W-1:0] node_mass;
        logic              last_node;
    } t_in;

    typedef struct packed {
        logic [NODE_W-1:0] start_node;
        logic [NODE_W-1:0] end_node;
        logic              found;
        logic              last_result;
    } t_out;

    typedef struct packed {
        logic [MASS_W-1:0] mass;
        logic              store;
        logic              scan;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MINMAX,
        S_LIMS,
        S_RDX,
        S_LDX,
        S_RDY1,
        S_CMP1,
        S_RDY2,
        S_EVAL,
        S_MATCH,
        S_EMIT,
        S_FINISH
    } t_state;

endpackage

// ===== rtl/mwf_front.sv =====
// Input side: accept items, count nodes, turn each stored or last item into a queue command.
`timescale 1ns / 1ps

module mwf_front #(
    parameter int MAX_NODES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mwf_pkg::t_in  i_in_data,
    input  logic          i_full,
    output logic          o_push,
    output mwf_pkg::t_cmd o_cmd
);

    localparam int CTR_W = $clog2(MAX_NODES + 1);

    logic [CTR_W-1:0] r_cnt;
    logic [CTR_W-1:0] n_cnt;
    logic             accept;
    logic             has_room;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;
    assign has_room   = (r_cnt < CTR_W'(MAX_NODES));

    assign o_cmd.mass  = i_in_data.node_mass;
    assign o_cmd.store = has_room;
    assign o_cmd.scan  = i_in_data.last_node;
    assign o_push      = accept && (has_room || i_in_data.last_node);

    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            if (i_in_data.last_node) begin
                n_cnt = '0;
            end else if (has_room) begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/mwf_queue.sv =====
// Two-entry command queue between the input side and the scan engine.
`timescale 1ns / 1ps

module mwf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mwf_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output mwf_pkg::t_cmd o_cmd
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mwf_pkg::t_cmd    r_data [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_data[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/mwf_back.sv =====
// Scan engine: mass store, configuration registers, two-pointer scan, result register.
`timescale 1ns / 1ps

module mwf_back #(
    parameter int MAX_NODES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  mwf_pkg::t_cmd                       i_q_cmd,
    output logic                                o_q_pop,
    input  logic                                i_cfg_valid,
    input  logic [mwf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mwf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output mwf_pkg::t_out                       o_out_data
);

    localparam int CTR_W = $clog2(MAX_NODES + 1);
    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CW    = mwf_pkg::CALC_W;

    logic [mwf_pkg::MASS_W-1:0]         r_mem [MAX_NODES];
    logic [mwf_pkg::MASS_W-1:0]         r_rd_data;
    logic                               rd_en;
    logic [IDX_W-1:0]                   rd_addr;

    logic [mwf_pkg::MASS_W-1:0]         r_prec;
    logic [mwf_pkg::TOL_W-1:0]          r_tol;
    logic [mwf_pkg::SCNT_W-1:0]         r_scnt;
    logic signed [mwf_pkg::SHIFT_W-1:0] r_shift [mwf_pkg::SHIFT_REGS];

    mwf_pkg::t_state                    r_state;
    mwf_pkg::t_state                    n_state;

    logic [CTR_W-1:0]                   r_cnt, n_cnt;
    logic [CTR_W-1:0]                   r_n, n_n;
    logic [CTR_W-1:0]                   r_x, n_x;
    logic [CTR_W-1:0]                   r_y, n_y;
    logic [CTR_W-1:0]                   r_wl, n_wl;
    logic [CTR_W-1:0]                   r_best, n_best;
    logic                               r_bv, n_bv;
    logic [mwf_pkg::MASS_W-1:0]         r_mx, n_mx;
    logic signed [CW-1:0]               r_mm_min, n_mm_min;
    logic signed [CW-1:0]               r_mm_max, n_mm_max;
    logic signed [CW-1:0]               r_lo, n_lo;
    logic signed [CW-1:0]               r_hi, n_hi;
    logic signed [CW-1:0]               r_d, n_d;
    logic                               r_pend_v, n_pend_v;
    mwf_pkg::t_out                      r_pend, n_pend;
    logic                               r_out_v, n_out_v;
    mwf_pkg::t_out                      r_out, n_out;

    logic                               out_free;
    logic signed [CW-1:0]               seg;
    logic signed [CW-1:0]               prec_c;
    logic signed [CW-1:0]               tol_c;
    logic [mwf_pkg::SCNT_W-1:0]         scnt_c;
    logic                               hit;
    logic                               wr_en;
    logic [IDX_W-1:0]                   wr_addr;

    assign out_free    = !r_out_v || i_out_ready;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;
    assign o_q_pop     = (r_state == mwf_pkg::S_IDLE) && i_q_valid;
    assign wr_en       = o_q_pop && i_q_cmd.store;
    assign wr_addr     = r_cnt[IDX_W-1:0];

    assign prec_c = {{(CW - mwf_pkg::MASS_W){1'b0}}, r_prec};
    assign tol_c  = {{(CW - mwf_pkg::TOL_W){1'b0}}, r_tol};
    assign seg    = {{(CW - mwf_pkg::MASS_W){1'b0}}, r_rd_data}
                  - {{(CW - mwf_pkg::MASS_W){1'b0}}, r_mx};
    assign scnt_c = (r_scnt > mwf_pkg::SCNT_W'(mwf_pkg::MAX_SHIFTS))
                  ? mwf_pkg::SCNT_W'(mwf_pkg::MAX_SHIFTS) : r_scnt;

    always_comb begin
        logic signed [CW-1:0] e;
        logic signed [CW-1:0] sh;
        hit = 1'b0;
        e = r_d;
        if (e >= -tol_c && e <= tol_c) begin
            hit = 1'b1;
        end
        e = r_d - tol_c;
        if (e >= -tol_c && e <= tol_c) begin
            hit = 1'b1;
        end
        for (int i = 0; i < mwf_pkg::SHIFT_REGS; i++) begin
            sh = {{(CW - mwf_pkg::SHIFT_W){r_shift[i][mwf_pkg::SHIFT_W-1]}}, r_shift[i]};
            e  = r_d - sh;
            if (mwf_pkg::SCNT_W'(i) < scnt_c && e >= -tol_c && e <= tol_c) begin
                hit = 1'b1;
            end
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_y[IDX_W-1:0];
        case (r_state)
            mwf_pkg::S_RDX: begin
                rd_en   = 1'b1;
                rd_addr = r_x[IDX_W-1:0];
            end
            mwf_pkg::S_RDY1, mwf_pkg::S_RDY2: begin
                rd_en = 1'b1;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mwf_pkg::S_IDLE: begin
                if (i_q_valid && i_q_cmd.scan) begin
                    n_state = mwf_pkg::S_MINMAX;
                end
            end
            mwf_pkg::S_MINMAX: n_state = mwf_pkg::S_LIMS;
            mwf_pkg::S_LIMS:   n_state = mwf_pkg::S_RDX;
            mwf_pkg::S_RDX: begin
                n_state = (r_x < r_n) ? mwf_pkg::S_LDX : mwf_pkg::S_FINISH;
            end
            mwf_pkg::S_LDX:    n_state = mwf_pkg::S_RDY1;
            mwf_pkg::S_RDY1: begin
                n_state = (r_y < r_n) ? mwf_pkg::S_CMP1 : mwf_pkg::S_FINISH;
            end
            mwf_pkg::S_CMP1: begin
                n_state = (seg < r_lo) ? mwf_pkg::S_RDY1 : mwf_pkg::S_EVAL;
            end
            mwf_pkg::S_EVAL: begin
                n_state = (seg <= r_hi) ? mwf_pkg::S_MATCH : mwf_pkg::S_EMIT;
            end
            mwf_pkg::S_MATCH:  n_state = mwf_pkg::S_RDY2;
            mwf_pkg::S_RDY2: begin
                n_state = (r_y < r_n) ? mwf_pkg::S_EVAL : mwf_pkg::S_EMIT;
            end
            mwf_pkg::S_EMIT: begin
                if (!(r_bv && r_pend_v && !out_free)) begin
                    n_state = mwf_pkg::S_RDX;
                end
            end
            mwf_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = mwf_pkg::S_IDLE;
                end
            end
            default: n_state = mwf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        logic signed [CW-1:0] shx;
        shx      = '0;
        n_cnt    = r_cnt;
        n_n      = r_n;
        n_x      = r_x;
        n_y      = r_y;
        n_wl     = r_wl;
        n_best   = r_best;
        n_bv     = r_bv;
        n_mx     = r_mx;
        n_mm_min = r_mm_min;
        n_mm_max = r_mm_max;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_d      = r_d;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_out_v  = r_out_v && !i_out_ready;
        n_out    = r_out;
        case (r_state)
            mwf_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_cmd.store) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            mwf_pkg::S_MINMAX: begin
                n_mm_min = '0;
                n_mm_max = tol_c;
                for (int i = 0; i < mwf_pkg::SHIFT_REGS; i++) begin
                    shx = {{(CW - mwf_pkg::SHIFT_W){r_shift[i][mwf_pkg::SHIFT_W-1]}},
                           r_shift[i]};
                    if (mwf_pkg::SCNT_W'(i) < scnt_c) begin
                        if (shx < n_mm_min) begin
                            n_mm_min = shx;
                        end
                        if (shx > n_mm_max) begin
                            n_mm_max = shx;
                        end
                    end
                end
                n_n = r_cnt;
            end
            mwf_pkg::S_LIMS: begin
                n_lo     = prec_c - r_mm_max - tol_c;
                n_hi     = prec_c - r_mm_min + tol_c;
                n_x      = '0;
                n_wl     = CTR_W'(1);
                n_pend_v = 1'b0;
            end
            mwf_pkg::S_LDX: begin
                n_mx = r_rd_data;
                n_y  = r_wl;
                n_bv = 1'b0;
            end
            mwf_pkg::S_CMP1: begin
                if (seg < r_lo) begin
                    n_y = r_y + 1'b1;
                end else begin
                    n_wl = r_y;
                end
            end
            mwf_pkg::S_EVAL: begin
                n_d = prec_c - seg;
            end
            mwf_pkg::S_MATCH: begin
                if (hit) begin
                    n_best = r_y;
                    n_bv   = 1'b1;
                end
                n_y = r_y + 1'b1;
            end
            mwf_pkg::S_EMIT: begin
                if (r_bv) begin
                    if (!r_pend_v || out_free) begin
                        if (r_pend_v) begin
                            n_out_v = 1'b1;
                            n_out   = r_pend;
                        end
                        n_pend_v           = 1'b1;
                        n_pend.start_node  = mwf_pkg::NODE_W'(r_x);
                        n_pend.end_node    = mwf_pkg::NODE_W'(r_best);
                        n_pend.found       = 1'b1;
                        n_pend.last_result = 1'b0;
                        n_x                = r_x + 1'b1;
                    end
                end else begin
                    n_x = r_x + 1'b1;
                end
            end
            mwf_pkg::S_FINISH: begin
                if (out_free) begin
                    n_out_v = 1'b1;
                    if (r_pend_v) begin
                        n_out = r_pend;
                    end else begin
                        n_out.start_node = '0;
                        n_out.end_node   = '0;
                        n_out.found      = 1'b0;
                    end
                    n_out.last_result = 1'b1;
                    n_pend_v          = 1'b0;
                    n_cnt             = '0;
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_q_cmd.mass;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prec <= '0;
            r_tol  <= mwf_pkg::DEFAULT_TOL;
            r_scnt <= '0;
            for (int i = 0; i < mwf_pkg::SHIFT_REGS; i++) begin
                r_shift[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mwf_pkg::REG_PRECURSOR: r_prec <= i_cfg_data[mwf_pkg::MASS_W-1:0];
                mwf_pkg::REG_TOLERANCE: r_tol  <= i_cfg_data[mwf_pkg::TOL_W-1:0];
                mwf_pkg::REG_SHIFT_CNT: r_scnt <= i_cfg_data[mwf_pkg::SCNT_W-1:0];
                mwf_pkg::REG_SHIFT_A:   r_shift[0] <= i_cfg_data[mwf_pkg::SHIFT_W-1:0];
                mwf_pkg::REG_SHIFT_B:   r_shift[1] <= i_cfg_data[mwf_pkg::SHIFT_W-1:0];
                mwf_pkg::REG_SHIFT_C:   r_shift[2] <= i_cfg_data[mwf_pkg::SHIFT_W-1:0];
                mwf_pkg::REG_SHIFT_D:   r_shift[3] <= i_cfg_data[mwf_pkg::SHIFT_W-1:0];
                default: r_scnt <= r_scnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_mx     <= n_mx;
        r_mm_min <= n_mm_min;
        r_mm_max <= n_mm_max;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_d      <= n_d;
        r_pend   <= n_pend;
        r_out    <= n_out;
        r_best   <= n_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mwf_pkg::S_IDLE;
            r_cnt    <= '0;
            r_n      <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_wl     <= CTR_W'(1);
            r_bv     <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_n      <= n_n;
            r_x      <= n_x;
            r_y      <= n_y;
            r_wl     <= n_wl;
            r_bv     <= n_bv;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

endmodule

// ===== rtl/prefix_mass_window_filter.sv =====
// Top level of the prefix mass window filter: input side, command queue, scan engine.
// Node items enter one per cycle while the two-entry queue is not full; input runs ahead.
// The scan sets bounds, then per start node loads its mass, moves the left edge past nodes
// below the window and tests nodes in it, then emits the last result; output stalls hold it.
// Nodes of the next protein are stored only after the last result item is registered.
// Reset is synchronous, active low; it restores register defaults, mass store left unset.
`timescale 1ns / 1ps

module prefix_mass_window_filter #(
    parameter int MAX_NODES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  mwf_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output mwf_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mwf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mwf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic          push;
    logic          full;
    logic          pop;
    logic          q_valid;
    mwf_pkg::t_cmd push_cmd;
    mwf_pkg::t_cmd q_cmd;

    assign o_cfg_ready = 1'b1;

    mwf_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    mwf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    mwf_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== tb/prefix_mass_window_filter_checker.sv =====
// Segment checker for the prefix mass window filter: predicts and compares every result item.
`timescale 1ns / 1ps

module prefix_mass_window_filter_checker
    import mwf_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in                   i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out                  i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int MAX_SEGMENTS = 64;

    logic [MASS_W-1:0]         precursor;
    logic [TOL_W-1:0]          tol;
    logic [SCNT_W-1:0]         shift_cnt;
    logic signed [SHIFT_W-1:0] shift_val [SHIFT_REGS];
    logic [MASS_W-1:0]         node_mass_q [MAX_NODES];
    int                        node_total;
    t_out                      segment_q [$];

    function automatic int active_shifts();
        return (shift_cnt > MAX_SHIFTS) ? MAX_SHIFTS : int'(shift_cnt);
    endfunction

    function automatic bit shift_fits(input longint d);
        longint t;
        longint e;
        bit     hit;
        t   = tol;
        hit = (d >= -t && d <= t) || (d - t >= -t && d - t <= t);
        for (int i = 0; i < active_shifts(); i++) begin
            e = d - longint'(shift_val[i]);
            if (e >= -t && e <= t) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic void predict_segments();
        longint t;
        longint prec;
        longint lo_shift;
        longint hi_shift;
        longint mx;
        int     n;
        int     left;
        int     y;
        int     best;
        int     seg_count;
        bit     have_best;
        bit     have_held;
        t_out   held;
        t         = tol;
        prec      = precursor;
        lo_shift  = 0;
        hi_shift  = t;
        n         = node_total;
        left      = 1;
        best      = 0;
        seg_count = 0;
        have_held = 1'b0;
        held      = '0;
        for (int i = 0; i < active_shifts(); i++) begin
            if (longint'(shift_val[i]) < lo_shift) lo_shift = shift_val[i];
            if (longint'(shift_val[i]) > hi_shift) hi_shift = shift_val[i];
        end
        for (int x = 0; x < n; x++) begin
            mx        = node_mass_q[x];
            have_best = 1'b0;
            y         = left;
            while (y < n && longint'(node_mass_q[y]) - mx - prec < -hi_shift - t) y++;
            if (y >= n) break;
            left = y;
            while (y < n && longint'(node_mass_q[y]) - mx - prec <= -lo_shift + t) begin
                if (shift_fits(prec - (longint'(node_mass_q[y]) - mx))) begin
                    best      = y;
                    have_best = 1'b1;
                end
                y++;
            end
            if (have_best && seg_count < MAX_SEGMENTS) begin
                if (have_held) segment_q = {segment_q, held};
                held      = '{start_node: NODE_W'(x), end_node: NODE_W'(best),
                              found: 1'b1, last_result: 1'b0};
                have_held = 1'b1;
                seg_count++;
            end
        end
        if (!have_held) held = '0;
        held.last_result = 1'b1;
        segment_q = {segment_q, held};
    endfunction

    always @(posedge i_clk) begin
        t_out exp_seg;
        if (!i_rst_n) begin
            precursor    = '0;
            tol          = DEFAULT_TOL;
            shift_cnt    = '0;
            for (int i = 0; i < SHIFT_REGS; i++) shift_val[i] = '0;
            node_total   = 0;
            segment_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_PRECURSOR: precursor = i_cfg_data[MASS_W-1:0];
                    REG_TOLERANCE: tol = i_cfg_data[TOL_W-1:0];
                    REG_SHIFT_CNT: shift_cnt = i_cfg_data[SCNT_W-1:0];
                    REG_SHIFT_A:   shift_val[0] = i_cfg_data[SHIFT_W-1:0];
                    REG_SHIFT_B:   shift_val[1] = i_cfg_data[SHIFT_W-1:0];
                    REG_SHIFT_C:   shift_val[2] = i_cfg_data[SHIFT_W-1:0];
                    REG_SHIFT_D:   shift_val[3] = i_cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (node_total < MAX_NODES) begin
                    node_mass_q[node_total] = i_in_data.node_mass;
                    node_total++;
                end
                if (i_in_data.last_node) begin
                    predict_segments();
                    node_total = 0;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (segment_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected item start=%0d end=%0d found=%0b last=%0b",
                                 $time, i_out_data.start_node, i_out_data.end_node,
                                 i_out_data.found, i_out_data.last_result);
                    o_fail_count++;
                end else begin
                    exp_seg = segment_q.pop_front();
                    if (exp_seg.start_node !== i_out_data.start_node ||
                        exp_seg.end_node !== i_out_data.end_node ||
                        exp_seg.found !== i_out_data.found ||
                        exp_seg.last_result !== i_out_data.last_result) begin
                        if (o_fail_count < 10)
                            $display({"%0t: mismatch expected start=%0d end=%0d found=%0b ",
                                      "last=%0b, got start=%0d end=%0d found=%0b last=%0b"},
                                     $time, exp_seg.start_node, exp_seg.end_node,
                                     exp_seg.found, exp_seg.last_result,
                                     i_out_data.start_node, i_out_data.end_node,
                                     i_out_data.found, i_out_data.last_result);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = segment_q.size();
    end

endmodule

// ===== tb/prefix_mass_window_filter_tb.sv =====
// Testbench top for the prefix mass window filter: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module prefix_mass_window_filter_tb;

    import mwf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 3'd7;
    localparam int                   SETTLE_CYCLES = 16;
    localparam int                   PHASES        = 6;
    localparam int                   PHASE_ITEMS   = 55;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in                   in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending;

    int send_idle_pct = 7;
    int recv_idle_pct = 68;
    int hold_cycles   = 0;
    int phase_items   = 0;
    int step_set [3];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    prefix_mass_window_filter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    prefix_mass_window_filter_checker seg_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_ready <= 1'b0;
            hold_cycles--;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_node(input logic [MASS_W-1:0] mass, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{node_mass: mass, last_node: last};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        phase_items++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_protein(input int len, input bit noisy, input logic [MASS_W-1:0] base);
        logic [MASS_W-1:0] mass;
        mass = base;
        for (int i = 0; i < len; i++) begin
            if (noisy) mass = MASS_W'($urandom);
            push_node(mass, i == len - 1);
            mass = mass + MASS_W'(step_set[$urandom_range(2)]);
        end
    endtask

    task automatic configure_phase(input int ph);
        int                    tolv;
        int                    cnt;
        int                    sh [4];
        longint                prec;
        logic [CFG_DATA_W-1:0] word;
        for (int i = 0; i < 3; i++) step_set[i] = $urandom_range(100, 5000);
        tolv = (ph == 1) ? 0 : (ph == 4) ? 65535 : $urandom_range(1, 400);
        cnt  = (ph * 3) % 8;
        for (int i = 0; i < 4; i++) sh[i] = int'($urandom_range(10000)) - 5000;
        if (ph == 2) begin
            sh[0] = -1048576;
            sh[1] = 1048575;
        end
        prec = 0;
        repeat ($urandom_range(1, 6)) prec += step_set[$urandom_range(2)];
        case ($urandom_range(2))
            0: ;
            1: prec += tolv;
            default: prec += (cnt > 0) ? sh[0] : 0;
        endcase
        prec += longint'($urandom_range(2 * tolv)) - tolv;
        if (prec < 0 || ph == 3) prec = 0;
        write_reg(REG_PRECURSOR, CFG_DATA_W'(prec));
        word = CFG_DATA_W'($urandom);
        word[TOL_W-1:0] = TOL_W'(tolv);
        write_reg(REG_TOLERANCE, word);
        word = CFG_DATA_W'($urandom);
        word[SCNT_W-1:0] = SCNT_W'(cnt);
        write_reg(REG_SHIFT_CNT, word);
        for (int i = 0; i < 4; i++) begin
            word = CFG_DATA_W'($urandom);
            word[SHIFT_W-1:0] = SHIFT_W'(sh[i]);
            write_reg(REG_SHIFT_A + CFG_IDX_W'(i), word);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int  r;
        int  proteins;
        logic [MASS_W-1:0] base;
        logic [CFG_DATA_W-1:0] word;
        step_set = '{100, 100, 100};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_node('0, 1'b1);
        wait_idle();
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(REG_PRECURSOR, 31'd200);
        cfg_valid <= 1'b0;
        @(negedge clk);
        send_protein(5, 1'b0, '0);

        wait_idle();
        write_reg(REG_PRECURSOR, 31'h7FFF_FFFF);
        write_reg(REG_TOLERANCE, 31'd0);
        write_reg(REG_SHIFT_CNT, 31'd7);
        write_reg(REG_SHIFT_A, 31'h0010_0000);
        write_reg(REG_SHIFT_B, 31'h000F_FFFF);
        word = CFG_DATA_W'($urandom);
        word[SHIFT_W-1:0] = '0;
        write_reg(REG_SHIFT_C, word);
        write_reg(REG_SHIFT_D, 31'd777);
        cfg_valid <= 1'b0;
        @(negedge clk);
        push_node('0, 1'b0);
        push_node(31'd1, 1'b0);
        push_node(31'h7FFF_FFFF, 1'b1);

        wait_idle();
        write_reg(REG_PRECURSOR, 31'd2000000);
        cfg_valid <= 1'b0;
        @(negedge clk);
        push_node('0, 1'b0);
        push_node(31'd951425, 1'b0);
        push_node(31'd3048576, 1'b1);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            configure_phase(ph);
            send_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 68 : 0;
            recv_idle_pct = (ph < 2) ? 68 : (ph < 4) ? 7 : 0;
            if (ph == 4) hold_cycles = 400;
            @(negedge clk);
            phase_items = 0;
            proteins    = 0;
            while (phase_items < PHASE_ITEMS) begin
                base = ($urandom_range(9) == 0) ? MASS_W'($urandom_range(2147000000)) : '0;
                r    = $urandom_range(99);
                if (ph == 3 && proteins == 0)
                    send_protein(70, 1'b0, '0);
                else if (r < 15)
                    send_protein($urandom_range(1, 8), 1'b1, '0);
                else if (r < 20)
                    send_protein($urandom_range(30, 64), 1'b0, base);
                else
                    send_protein($urandom_range(2, 16), 1'b0, base);
                proteins++;
                if (ph == 1 && proteins == 2) begin
                    in_valid <= 1'b0;
                    while (pending != 0) @(negedge clk);
                end
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
